### design/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Slot record, chain command codes and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int ID_BITS     = 16;
  localparam int IV_BITS     = 32;
  localparam int CFG_BITS    = 20;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_BITS-1:0] MIN_ARM_RESET = CFG_BITS'(100);

  typedef enum logic [1:0] {
    CMD_NOP = 2'd0,
    CMD_INS = 2'd1,
    CMD_POP = 2'd2
  } chain_cmd_t;

  typedef struct packed {
    logic                 occ;
    logic [TIME_BITS-1:0] dl;
    logic [ID_BITS-1:0]   id;
    logic                 rep;
    logic [IV_BITS-1:0]   iv;
  } slot_t;

  typedef struct packed {
    chain_cmd_t cmd;
    slot_t      ent;
  } chain_ctl_t;

  typedef struct packed {
    slot_t head;
    logic  head_go;
  } chain_sts_t;

endpackage

`default_nettype wire

### design/deadline_timer_queue.sv
// Sequence: an add passes S_ADD, S_ARM1, S_ARM2 and S_EMIT; a tick firing
//   k timers pops them in S_POP, reinserts the repeating ones through
//   S_RSUM and S_RINS, forms the arm delay in S_ARM1 and S_ARM2, then emits
//   k results (one if k = 0).
// Flow: one transaction at a time; a new request is taken only in S_IDLE.
// Reset: synchronous, active low; empties the queue, sets minimum delay 100.
// ----------------------------------------------------------------------------
// deadline_timer_queue: sorted timer queue with tick-driven expiry
// Sequencer around a chain of timer cells plus a fired-timer buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_queue import dtq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration: minimum arm delay
  input  logic                 cfg_wr_en,
  input  logic [CFG_BITS-1:0]  cfg_wr_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [ID_BITS-1:0]   in_timer_id,
  input  logic [TIME_BITS-1:0] in_deadline_us,
  input  logic                 in_repeats,
  input  logic [IV_BITS-1:0]   in_interval_us,
  input  logic [TIME_BITS-1:0] in_now_us,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_fired_valid,
  output logic [ID_BITS-1:0]   out_fired_id,
  output logic                 out_last,
  output logic                 out_new_earliest,
  output logic                 out_dropped,
  output logic [CNT_W-1:0]     out_pending_count,
  output logic                 out_arm_valid,
  output logic [TIME_BITS-1:0] out_arm_delay_us
);

  localparam int SUM_W = TIME_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,  // wait for a request
    S_ADD  = 8'b0000_0010,  // insert the new timer or drop it
    S_POP  = 8'b0000_0100,  // pop due timers off the head, one a cycle
    S_RSUM = 8'b0000_1000,  // scan fired list, form restart deadline
    S_RINS = 8'b0001_0000,  // reinsert a repeating timer
    S_ARM1 = 8'b0010_0000,  // head deadline minus now
    S_ARM2 = 8'b0100_0000,  // clamp to the minimum
    S_EMIT = 8'b1000_0000   // hand results to the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic                 is_tick_r, is_tick_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  slot_t                ins_r, ins_nxt;
  logic                 ec_r, ec_nxt;
  logic                 drop_r, drop_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic [TIME_BITS-1:0] diff_r, diff_nxt;
  logic [TIME_BITS-1:0] delay_r, delay_nxt;
  logic [CFG_BITS-1:0]  min_arm_r;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 o_fv_r, o_fv_nxt;
  logic [ID_BITS-1:0]   o_id_r, o_id_nxt;
  logic                 o_last_r, o_last_nxt;
  logic                 o_ec_r, o_ec_nxt;
  logic                 o_drop_r, o_drop_nxt;
  logic [CNT_W-1:0]     o_cnt_r, o_cnt_nxt;
  logic                 o_av_r, o_av_nxt;
  logic [TIME_BITS-1:0] o_delay_r, o_delay_nxt;

  // fired-timer buffer, filled in pop order
  logic [ID_BITS-1:0]   buf_id_r  [QUEUE_DEPTH];
  logic                 buf_rep_r [QUEUE_DEPTH];
  logic [IV_BITS-1:0]   buf_iv_r  [QUEUE_DEPTH];
  logic                 buf_we;

  chain_ctl_t           chain_ctl;
  chain_sts_t           chain_sts;

  logic [IDX_W-1:0]     ptr_idx;
  logic                 head_due;
  logic [SUM_W-1:0]     sum_w;
  logic [SUM_W-1:0]     sub_w;
  logic [TIME_BITS-1:0] min_eff;

  dtq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (chain_ctl),
    .sts_o (chain_sts)
  );

  assign ptr_idx  = ptr_r[IDX_W-1:0];
  // Head is due when occupied and its deadline is at or before now
  assign head_due = chain_sts.head.occ && (chain_sts.head.dl <= now_r);
  // Restart deadline; the carry bit flags overflow of the time range
  assign sum_w    = {1'b0, now_r} + SUM_W'(buf_iv_r[ptr_idx]);
  // Borrow bit set means the head deadline is already past
  assign sub_w    = {1'b0, chain_sts.head.dl} - {1'b0, now_r};
  // A zero minimum acts as one microsecond
  assign min_eff  = (min_arm_r == '0) ? TIME_BITS'(1) : TIME_BITS'(min_arm_r);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    is_tick_nxt   = is_tick_r;
    now_nxt       = now_r;
    ins_nxt       = ins_r;
    ec_nxt        = ec_r;
    drop_nxt      = drop_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    diff_nxt      = diff_r;
    delay_nxt     = delay_r;
    out_valid_nxt = out_valid_r;
    o_fv_nxt      = o_fv_r;
    o_id_nxt      = o_id_r;
    o_last_nxt    = o_last_r;
    o_ec_nxt      = o_ec_r;
    o_drop_nxt    = o_drop_r;
    o_cnt_nxt     = o_cnt_r;
    o_av_nxt      = o_av_r;
    o_delay_nxt   = o_delay_r;
    chain_ctl.cmd = CMD_NOP;
    chain_ctl.ent = ins_r;
    buf_we        = 1'b0;

    // Retire the held result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          is_tick_nxt = in_req_type;
          now_nxt     = in_now_us;
          ins_nxt.occ = 1'b1;
          ins_nxt.dl  = in_deadline_us;
          ins_nxt.id  = in_timer_id;
          ins_nxt.rep = in_repeats;
          ins_nxt.iv  = in_interval_us;
          ec_nxt      = 1'b0;
          drop_nxt    = 1'b0;
          k_nxt       = '0;
          ptr_nxt     = '0;
          state_nxt   = in_req_type ? S_POP : S_ADD;
        end
      end
      S_ADD: begin
        if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
          drop_nxt = 1'b1;
        end else begin
          chain_ctl.cmd = CMD_INS;
          // New timer lands in cell 0 exactly when it is the new earliest
          ec_nxt        = chain_sts.head_go;
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
        state_nxt = S_ARM1;
      end
      S_POP: begin
        if (head_due) begin
          chain_ctl.cmd = CMD_POP;
          buf_we        = 1'b1;
          k_nxt         = k_r + CNT_W'(1);
          cnt_nxt       = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = S_RSUM;
        end
      end
      S_RSUM: begin
        if (ptr_r == k_r) begin
          ptr_nxt   = '0;
          state_nxt = S_ARM1;
        end else if (buf_rep_r[ptr_idx]) begin
          ins_nxt.occ = 1'b1;
          ins_nxt.dl  = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
          ins_nxt.id  = buf_id_r[ptr_idx];
          ins_nxt.rep = 1'b1;
          ins_nxt.iv  = buf_iv_r[ptr_idx];
          state_nxt   = S_RINS;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_RINS: begin
        chain_ctl.cmd = CMD_INS;
        cnt_nxt       = cnt_r + CNT_W'(1);
        ptr_nxt       = ptr_r + CNT_W'(1);
        state_nxt     = S_RSUM;
      end
      S_ARM1: begin
        diff_nxt  = sub_w[TIME_BITS] ? '0 : sub_w[TIME_BITS-1:0];
        state_nxt = S_ARM2;
      end
      S_ARM2: begin
        delay_nxt = (diff_r < min_eff) ? min_eff : diff_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_cnt_nxt     = cnt_r;
          o_av_nxt      = (cnt_r != '0);
          o_delay_nxt   = (cnt_r != '0) ? delay_r : '0;
          o_ec_nxt      = 1'b0;
          o_drop_nxt    = 1'b0;
          if (is_tick_r && (k_r != '0)) begin
            // One result per fired timer, in firing order
            o_fv_nxt   = 1'b1;
            o_id_nxt   = buf_id_r[ptr_idx];
            o_last_nxt = (ptr_r == k_r - CNT_W'(1));
            ptr_nxt    = ptr_r + CNT_W'(1);
            if (ptr_r == k_r - CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end else begin
            // Add result, or empty tick
            o_fv_nxt   = 1'b0;
            o_id_nxt   = '0;
            o_last_nxt = 1'b1;
            o_ec_nxt   = is_tick_r ? 1'b0 : ec_r;
            o_drop_nxt = is_tick_r ? 1'b0 : drop_r;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      min_arm_r   <= MIN_ARM_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        min_arm_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers hold no reset
  always_ff @(posedge clk) begin
    is_tick_r <= is_tick_nxt;
    now_r     <= now_nxt;
    ins_r     <= ins_nxt;
    ec_r      <= ec_nxt;
    drop_r    <= drop_nxt;
    diff_r    <= diff_nxt;
    delay_r   <= delay_nxt;
    o_fv_r    <= o_fv_nxt;
    o_id_r    <= o_id_nxt;
    o_last_r  <= o_last_nxt;
    o_ec_r    <= o_ec_nxt;
    o_drop_r  <= o_drop_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_av_r    <= o_av_nxt;
    o_delay_r <= o_delay_nxt;
  end

  // Capture each popped head into the fired buffer
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_id_r[k_r[IDX_W-1:0]]  <= chain_sts.head.id;
      buf_rep_r[k_r[IDX_W-1:0]] <= chain_sts.head.rep;
      buf_iv_r[k_r[IDX_W-1:0]]  <= chain_sts.head.iv;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired_valid   = o_fv_r;
  assign out_fired_id      = o_id_r;
  assign out_last          = o_last_r;
  assign out_new_earliest  = o_ec_r;
  assign out_dropped       = o_drop_r;
  assign out_pending_count = o_cnt_r;
  assign out_arm_valid     = o_av_r;
  assign out_arm_delay_us  = o_delay_r;

endmodule

`default_nettype wire

### design/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted timer chain
// Holds one timer; shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_cell import dtq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl_i,
  input  slot_t      left_i,
  input  logic       left_go_i,
  input  slot_t      right_i,
  output slot_t      slot_o,
  output logic       go_o
);

  slot_t slot_r;
  slot_t slot_nxt;

  // New timer belongs here or earlier: slot empty or strictly later deadline
  assign go_o   = !slot_r.occ || (ctl_i.ent.dl < slot_r.dl);
  assign slot_o = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    case (ctl_i.cmd)
      CMD_INS: begin
        if (left_go_i) begin
          slot_nxt = left_i;
        end else if (go_o) begin
          slot_nxt     = ctl_i.ent;
          slot_nxt.occ = 1'b1;
        end
      end
      CMD_POP: begin
        slot_nxt = right_i;
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.occ <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

### design/dtq_chain.sv
// ----------------------------------------------------------------------------
// dtq_chain: row of timer cells kept sorted by deadline
// Cell 0 holds the earliest timer; occupied cells form a prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_chain import dtq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl_i,
  output chain_sts_t sts_o
);

  slot_t slot_w [QUEUE_DEPTH];
  logic  go_w   [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_s;
    logic  left_go_s;
    slot_t right_s;

    if (i == 0) begin : g_first
      assign left_s    = '0;
      assign left_go_s = 1'b0;
    end else begin : g_mid
      assign left_s    = slot_w[i-1];
      assign left_go_s = go_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = slot_w[i+1];
    end

    dtq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl_i),
      .left_i    (left_s),
      .left_go_i (left_go_s),
      .right_i   (right_s),
      .slot_o    (slot_w[i]),
      .go_o      (go_w[i])
    );
  end

  assign sts_o.head    = slot_w[0];
  assign sts_o.head_go = go_w[0];

endmodule

`default_nettype wire

### tb/tb_deadline_timer_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue: self-checking testbench of the deadline timer queue
// Feeds add and tick requests through a valid/ready driver, predicts every
// result with a sorted timer list of its own, and checks each result field
// by field. Minimum arm delay changes between phases; both sides stall at
// random, with one long result-side hold that backs the block up.
// ----------------------------------------------------------------------------

module tb_deadline_timer_queue;
  import dtq_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [IV_BITS-1:0]   IV_MAX   = {IV_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] TIME_MSB = {1'b1, {(TIME_BITS-1){1'b0}}};

  localparam logic [CFG_BITS-1:0] MIN_DELAY_ONE   = CFG_BITS'(1);
  localparam logic [CFG_BITS-1:0] MIN_DELAY_MID   = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] MIN_DELAY_ZERO  = CFG_BITS'(0);
  localparam logic [CFG_BITS-1:0] MIN_DELAY_TOP   = CFG_BITS'(1000000);
  localparam logic [CFG_BITS-1:0] MIN_DELAY_ONES  = {CFG_BITS{1'b1}};

  localparam int MAX_GAP          = 17;
  localparam int LONG_HOLD_CYCLES = 400;
  // Final drain; a worst tick makes 16 pops, 16 reinserts and arm math.
  localparam int DRAIN_CYCLES     = 64;
  localparam int RANDOM_REPEATERS = 6;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t            kind;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] deadline;
    logic                 repeats;
    logic [IV_BITS-1:0]   interval;
    logic [TIME_BITS-1:0] now;
  } timer_req_t;

  typedef struct packed {
    logic                 fired_valid;
    logic [ID_BITS-1:0]   fired_id;
    logic                 last;
    logic                 new_earliest;
    logic                 dropped;
    logic [CNT_W-1:0]     pending;
    logic                 arm_valid;
    logic [TIME_BITS-1:0] arm_delay;
  } timer_result_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [ID_BITS-1:0]   id;
    logic                 repeats;
    logic [IV_BITS-1:0]   interval;
  } timer_entry_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0]  cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic [ID_BITS-1:0]   in_timer_id = '0;
  logic [TIME_BITS-1:0] in_deadline_us = '0;
  logic                 in_repeats = 1'b0;
  logic [IV_BITS-1:0]   in_interval_us = '0;
  logic [TIME_BITS-1:0] in_now_us = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_fired_valid;
  logic [ID_BITS-1:0]   out_fired_id;
  logic                 out_last;
  logic                 out_new_earliest;
  logic                 out_dropped;
  logic [CNT_W-1:0]     out_pending_count;
  logic                 out_arm_valid;
  logic [TIME_BITS-1:0] out_arm_delay_us;

  always #6 clk = ~clk;

  deadline_timer_queue dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_timer_id          (in_timer_id),
    .in_deadline_us       (in_deadline_us),
    .in_repeats           (in_repeats),
    .in_interval_us       (in_interval_us),
    .in_now_us            (in_now_us),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_fired_valid      (out_fired_valid),
    .out_fired_id         (out_fired_id),
    .out_last             (out_last),
    .out_new_earliest     (out_new_earliest),
    .out_dropped          (out_dropped),
    .out_pending_count    (out_pending_count),
    .out_arm_valid        (out_arm_valid),
    .out_arm_delay_us     (out_arm_delay_us)
  );

  // --------------------------------------------------------------------------
  // Timer list mirror: sorted by deadline, ties in arrival order
  // --------------------------------------------------------------------------
  timer_entry_t        pend_timers [QUEUE_DEPTH];
  int                  pend_count = 0;
  logic [CFG_BITS-1:0] min_delay_setting = MIN_ARM_RESET;

  timer_req_t    req_q[$];        // requests waiting for the driver
  timer_result_t expected_q[$];   // results the block still owes
  int            n_errors = 0;

  // Phase knobs, written by the stimulus process only.
  logic sender_steady = 1'b0;
  logic receiver_steady = 1'b0;
  logic pressure_on = 1'b0;

  function automatic logic [TIME_BITS-1:0] arm_delay_for(input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] floor_us;
    logic [TIME_BITS-1:0] gap_us;
    // A zero minimum still arms at least one microsecond out.
    floor_us = (min_delay_setting == '0) ? TIME_BITS'(1) : TIME_BITS'(min_delay_setting);
    gap_us = (pend_timers[0].deadline > now) ? pend_timers[0].deadline - now : '0;
    return (gap_us < floor_us) ? floor_us : gap_us;
  endfunction

  function automatic void insert_timer(input timer_entry_t t);
    int pos;
    int i;
    pos = 0;
    if (pend_count >= QUEUE_DEPTH) return;
    // Land after every entry with an equal or earlier deadline.
    while (pos < pend_count && pend_timers[pos].deadline <= t.deadline) pos++;
    for (i = pend_count; i > pos; i--) pend_timers[i] = pend_timers[i-1];
    pend_timers[pos] = t;
    pend_count++;
  endfunction

  function automatic void expect_result(input logic fv, input logic [ID_BITS-1:0] fid,
                                        input logic last, input logic ec, input logic dropped,
                                        input logic [TIME_BITS-1:0] now);
    timer_result_t r;
    r.fired_valid  = fv;
    r.fired_id     = fid;
    r.last         = last;
    r.new_earliest = ec;
    r.dropped      = dropped;
    r.pending      = CNT_W'(pend_count);
    r.arm_valid    = (pend_count > 0);
    r.arm_delay    = (pend_count > 0) ? arm_delay_for(now) : '0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Advance the mirror by one accepted request and queue what it owes.
  function automatic void apply_request(input timer_req_t rq);
    timer_entry_t         fired [QUEUE_DEPTH];
    timer_entry_t         t;
    logic                 ec;
    logic [TIME_BITS:0]   restart;
    int                   k;
    int                   i;
    if (rq.kind == REQ_ADD) begin
      if (pend_count >= QUEUE_DEPTH) begin
        // Full: refuse the timer, leave the list alone.
        expect_result(1'b0, '0, 1'b1, 1'b0, 1'b1, rq.now);
      end else begin
        ec = (pend_count == 0) || (rq.deadline < pend_timers[0].deadline);
        t.deadline = rq.deadline;
        t.id       = rq.id;
        t.repeats  = rq.repeats;
        t.interval = rq.interval;
        insert_timer(t);
        expect_result(1'b0, '0, 1'b1, ec, 1'b0, rq.now);
      end
    end else begin
      // Pop every due timer from the head.
      k = 0;
      while (k < pend_count && pend_timers[k].deadline <= rq.now) begin
        fired[k] = pend_timers[k];
        k++;
      end
      for (i = k; i < pend_count; i++) pend_timers[i-k] = pend_timers[i];
      pend_count -= k;
      // Re-enter repeaters only after the whole batch is out, in firing order.
      for (i = 0; i < k; i++) begin
        if (fired[i].repeats) begin
          restart = {1'b0, rq.now} + (TIME_BITS+1)'(fired[i].interval);
          t = fired[i];
          t.deadline = restart[TIME_BITS] ? TIME_MAX : restart[TIME_BITS-1:0];
          insert_timer(t);
        end
      end
      if (k == 0) expect_result(1'b0, '0, 1'b1, 1'b0, 1'b0, rq.now);
      for (i = 0; i < k; i++) expect_result(1'b1, fired[i].id, i == k - 1, 1'b0, 1'b0, rq.now);
    end
  endfunction

  function automatic int draw_gap(input logic steady);
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void check_field(input string name, input logic [TIME_BITS-1:0] want,
                                      input logic [TIME_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: one transaction in flight, random gap before each one
  // --------------------------------------------------------------------------
  timer_req_t cur_req;
  logic       offering = 1'b0;
  int         send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(cur_req);
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_req_type    <= cur_req.kind;
          in_timer_id    <= cur_req.id;
          in_deadline_us <= cur_req.deadline;
          in_repeats     <= cur_req.repeats;
          in_interval_us <= cur_req.interval;
          in_now_us      <= cur_req.now;
          offering = 1'b1;
          send_gap = draw_gap(sender_steady);
        end
      end
      // Single write per edge keeps valid high across back-to-back items.
      in_valid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted transaction, then stall at random
  // --------------------------------------------------------------------------
  int   stall_left = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin
    timer_result_t want;
    logic          rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing pending: fired_id %0h", out_fired_id);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("fired_valid", want.fired_valid, out_fired_valid);
          check_field("fired_id", want.fired_id, out_fired_id);
          check_field("last", want.last, out_last);
          check_field("new_earliest", want.new_earliest, out_new_earliest);
          check_field("dropped", want.dropped, out_dropped);
          check_field("pending_count", want.pending, out_pending_count);
          check_field("arm_valid", want.arm_valid, out_arm_valid);
          check_field("arm_delay_us", want.arm_delay, out_arm_delay_us);
        end
        stall_left = draw_gap(receiver_steady);
      end
      // Hold off once for a long stretch so the block backs up into its input.
      if (pressure_on && !long_hold_done) begin
        stall_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0] gen_now = '0;
  int                   repeat_budget = RANDOM_REPEATERS;

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // Saturate instead of wrapping: time never wraps.
  function automatic logic [TIME_BITS-1:0] time_after(input logic [TIME_BITS-1:0] t,
                                                      input int unsigned step);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, t} + (TIME_BITS+1)'(step);
    return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

  function automatic void queue_add(input logic [ID_BITS-1:0] id,
                                    input logic [TIME_BITS-1:0] deadline,
                                    input logic rep, input logic [IV_BITS-1:0] iv);
    timer_req_t rq;
    rq.kind     = REQ_ADD;
    rq.id       = id;
    rq.deadline = deadline;
    rq.repeats  = rep;
    rq.interval = iv;
    rq.now      = gen_now;
    req_q.insert(req_q.size(), rq);
  endfunction

  // Randomize the fields a tick ignores.
  function automatic void queue_tick(input logic [TIME_BITS-1:0] now);
    timer_req_t rq;
    rq.kind     = REQ_TICK;
    rq.id       = ID_BITS'($urandom);
    rq.deadline = rand_time();
    rq.repeats  = 1'($urandom_range(0, 1));
    rq.interval = $urandom;
    rq.now      = now;
    req_q.insert(req_q.size(), rq);
  endfunction

  // Mostly a steadily advancing clock with adds just ahead of it; the rest
  // is stray ticks and adds with arbitrary deadlines.
  task automatic queue_random_phase(input int n_items, input int add_pct);
    int                   n;
    int                   sel;
    logic                 rep;
    logic [IV_BITS-1:0]   iv;
    logic [TIME_BITS-1:0] dl;
    for (n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < add_pct) begin
        rep = 1'b0;
        iv = IV_BITS'($urandom_range(0, 3000));
        if (repeat_budget > 0 && $urandom_range(0, 7) == 0) begin
          rep = 1'b1;
          repeat_budget--;
        end
        if ($urandom_range(0, 9) == 0) iv = $urandom;
        if ($urandom_range(0, 7) == 0)
          dl = (gen_now > 500) ? gen_now - TIME_BITS'($urandom_range(0, 500)) : '0;
        else
          dl = time_after(gen_now, $urandom_range(0, 4000));
        queue_add(ID_BITS'($urandom), dl, rep, iv);
      end else if (sel < 90) begin
        gen_now = time_after(gen_now, $urandom_range(0, 2500));
        queue_tick(gen_now);
      end else if (sel < 96) begin
        queue_add(ID_BITS'($urandom), rand_time(), 1'b0, $urandom);
      end else begin
        queue_tick(rand_time());
      end
    end
  endtask

  // Sampled at the falling edge, clear of the clocked processes.
  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || expected_q.size() != 0);
  endtask

  task automatic write_min_delay(input logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    min_delay_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tick, a deadline equal to now, then fill to the brim.
    queue_tick('0);
    queue_add(16'h0000, '0, 1'b0, '0);
    gen_now = TIME_BITS'(1000);
    queue_add(16'hFFFF, TIME_BITS'(5000), 1'b0, IV_MAX);
    queue_add(16'h0001, TIME_BITS'(5000), 1'b0, '0);         // tie keeps order
    queue_add(16'h0002, TIME_BITS'(3000), 1'b1, '0);         // zero interval
    queue_add(16'h0003, TIME_BITS'(2000), 1'b1, IV_MAX);
    queue_add(16'h0004, TIME_MAX - 500, 1'b1, IV_BITS'(1000)); // restart saturates
    queue_add(16'h0005, TIME_MAX, 1'b0, '0);
    for (i = 7; i < QUEUE_DEPTH; i++)                        // some already past
      queue_add(ID_BITS'(16'h0010 + i), TIME_BITS'(150 * (i - 7)), 1'b0, '0);
    queue_add(16'h1234, TIME_BITS'(10), 1'b1, IV_BITS'(7));  // full: refused
    queue_tick(TIME_BITS'(4000));                            // large batch fires
    queue_tick(TIME_BITS'(4000));                            // zero interval again
    queue_tick(TIME_MSB);
    queue_tick(TIME_MAX - 100);
    queue_tick(TIME_MAX);
    wait_idle();

    // Smallest minimum, ordinary times.
    write_min_delay(MIN_DELAY_ONE);
    gen_now = TIME_BITS'($urandom_range(0, 1000000));
    queue_random_phase(37, 48);
    wait_idle();

    // Add-heavy with a long result-side hold; sender never idles.
    write_min_delay(MIN_DELAY_MID);
    sender_steady = 1'b1;
    pressure_on = 1'b1;
    queue_random_phase(50, 75);
    wait_idle();

    // Zero minimum, clock jumped into the upper half of the range.
    write_min_delay(MIN_DELAY_ZERO);
    sender_steady = 1'b0;
    receiver_steady = 1'b1;
    gen_now = TIME_MSB | (rand_time() >> 2);
    queue_random_phase(40, 48);
    wait_idle();

    // A minimum of one million microseconds, clock right under the end of time.
    write_min_delay(MIN_DELAY_TOP);
    receiver_steady = 1'b0;
    gen_now = TIME_MAX - TIME_BITS'($urandom_range(0, 20000));
    queue_random_phase(40, 48);
    wait_idle();

    // All register bits set.
    write_min_delay(MIN_DELAY_ONES);
    gen_now = TIME_BITS'($urandom_range(0, 1000000));
    queue_random_phase(40, 48);
    wait_idle();

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
